// ===== src/aral_pkg.sv =====
package aral_pkg;

    localparam int MAX_RANGES = 256;
    localparam int PAGE_BYTES = 4096;  // power of two
    localparam int ADDR_W     = 32;
    localparam int LEN_W      = ADDR_W + 1;
    localparam int IDX_W      = $clog2(MAX_RANGES);
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);

    localparam logic [ADDR_W-1:0] PAGE_MASK = ADDR_W'(PAGE_BYTES - 1);

    localparam logic [1:0] ACT_PLACE = 2'd0;
    localparam logic [1:0] ACT_FIXED = 2'd1;
    localparam logic [1:0] ACT_FREE  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOSPACE  = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] rng_start;
        logic [ADDR_W-1:0] rng_end;
    } t_entry;

endpackage

// ===== src/aral_cell.sv =====
module aral_cell (
    input  logic            i_clk,
    input  logic            i_shift,
    input  aral_pkg::t_entry i_d,
    output aral_pkg::t_entry o_q
);
    import aral_pkg::*;

    t_entry r_entry;

    // one table entry, handed to the left neighbor on every shift
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_entry <= i_d;
        end
    end

    assign o_q = r_entry;

endmodule

// ===== src/address_range_allocator.sv =====
// flow: an accepted request scans every entry in one full turn of the cell ring, then waits
// until the result register is free and loads the result into it
// one request at a time: o_stall stays high from accept until the result is loaded
// reset: synchronous active low; clears range count, top limit and handshake state,
// table contents stay undefined (only entries below the count are ever used)
module address_range_allocator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_action,
    input  logic [aral_pkg::ADDR_W-1:0]  i_address,
    input  logic [aral_pkg::ADDR_W-1:0]  i_length,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [aral_pkg::ADDR_W-1:0]  o_start_address,
    output logic [1:0]                   o_status,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [aral_pkg::ADDR_W-1:0]  i_top_limit
);
    import aral_pkg::*;

    // ring of cells: entry k sits in cell k when idle; during a scan
    // the ring turns left once, so cell 0 shows entries 0,1,2.. in order
    // and the edited stream goes back in at the far end
    t_entry w_q [MAX_RANGES];
    t_entry w_emit;
    logic   w_shift;

    genvar g;
    generate
        for (g = 0; g < MAX_RANGES; g++) begin : g_cell
            if (g == MAX_RANGES - 1) begin : g_tail
                aral_cell u_cell (
                    .i_clk  (i_clk),
                    .i_shift(w_shift),
                    .i_d    (w_emit),
                    .o_q    (w_q[g])
                );
            end else begin : g_body
                aral_cell u_cell (
                    .i_clk  (i_clk),
                    .i_shift(w_shift),
                    .i_d    (w_q[g+1]),
                    .o_q    (w_q[g])
                );
            end
        end
    endgenerate

    // control state
    logic                r_busy, r_wait, r_hit, r_fail, r_ins, r_del;
    logic [IDX_W-1:0]    r_t;
    logic [CNT_W-1:0]    r_count;
    logic [ADDR_W-1:0]   r_top;
    logic                r_o_valid;

    // request and scan payload
    logic [1:0]          r_act;
    logic [ADDR_W-1:0]   r_addr;
    logic [LEN_W-1:0]    r_len;
    logic [ADDR_W-1:0]   r_prev_end;
    t_entry              r_hold;
    logic [ADDR_W-1:0]   r_res_start;
    logic [1:0]          r_res_status;
    logic [ADDR_W-1:0]   r_o_start;
    logic [1:0]          r_o_status;

    logic                w_accept, w_scan, w_vld, w_tail, w_last, w_out_free, w_finish;
    logic [ADDR_W-1:0]   w_base;
    logic [LEN_W:0]      w_base_end, w_addr_end;
    logic                w_hit, w_fail, w_commit;
    logic [ADDR_W-1:0]   w_where;
    logic [LEN_W-1:0]    w_len_al;
    logic [1:0]          w_fin_status;
    t_entry              w_cur, w_new;

    assign o_stall     = r_busy;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_valid && !r_busy;
    assign w_scan      = r_busy && !r_wait;
    assign w_shift     = w_scan;
    assign w_cur       = w_q[0];
    assign w_last      = (r_t == IDX_W'(MAX_RANGES - 1));
    assign w_vld       = ({1'b0, r_t} < CNT_W'(r_count));
    assign w_tail      = ({1'b0, r_t} == CNT_W'(r_count));

    // round length up to a page, 33 bits since it can pass 2^32-1
    assign w_len_al = ({1'b0, i_length} + LEN_W'(PAGE_MASK)) & ~LEN_W'(PAGE_MASK);

    // gap below entry t starts at the end of entry t-1, or at zero
    assign w_base     = (r_t == '0) ? '0 : r_prev_end;
    assign w_base_end = {2'b00, w_base} + {1'b0, r_len};
    assign w_addr_end = {2'b00, r_addr} + {1'b0, r_len};

    // search decision for the entry at the head of the ring
    always_comb begin
        w_hit   = 1'b0;
        w_fail  = 1'b0;
        w_where = r_addr;
        if (w_scan && !r_hit && !r_fail) begin
            case (r_act)
                ACT_PLACE: begin
                    w_where = w_base;
                    if (w_vld) begin
                        if (w_base >= r_addr && w_base_end <= (LEN_W+1)'(w_cur.rng_start))
                            w_hit = 1'b1;
                    end else if (w_tail) begin
                        if (r_count == '0) begin
                            // empty table: take the hint, only the 32-bit limit applies
                            w_where = r_addr;
                            w_hit   = (w_addr_end <= (LEN_W+1)'({ADDR_W{1'b1}}));
                            w_fail  = !w_hit;
                        end else begin
                            // space after the last range, up to the top limit
                            w_hit  = (w_base_end <= (LEN_W+1)'(r_top));
                            w_fail = !w_hit;
                        end
                    end
                end
                ACT_FIXED: begin
                    if (w_vld) begin
                        if (w_base > r_addr)
                            w_fail = 1'b1;
                        else if (w_addr_end <= (LEN_W+1)'(w_cur.rng_start))
                            w_hit = 1'b1;
                    end else if (w_tail) begin
                        w_hit  = (r_count == '0) &&
                                 (w_addr_end <= (LEN_W+1)'({ADDR_W{1'b1}}));
                        w_fail = !w_hit;
                    end
                end
                ACT_FREE: begin
                    w_where = w_cur.rng_start;
                    if (w_vld && r_addr >= w_cur.rng_start && r_addr < w_cur.rng_end)
                        w_hit = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // an insert only goes in while there is room
    assign w_commit = w_hit && (r_act != ACT_FREE) &&
                      (r_count != CNT_W'(MAX_RANGES));
    assign w_new.rng_start = w_where;
    assign w_new.rng_end   = w_where + r_len[ADDR_W-1:0];

    // edited stream into the far end of the ring
    always_comb begin
        if (r_ins)
            w_emit = r_hold;            // everything after the slot moves up one
        else if (w_commit)
            w_emit = w_new;
        else if (r_del || (w_hit && r_act == ACT_FREE))
            w_emit = w_q[1];            // skip the freed entry
        else
            w_emit = w_cur;
    end

    // result once the ring is back home; a full table whose tail has room reports full
    always_comb begin
        w_fin_status = r_res_status;
        if (!r_hit && !r_fail && r_act == ACT_PLACE && r_count == CNT_W'(MAX_RANGES) &&
            ({2'b00, r_prev_end} + {1'b0, r_len}) <= (LEN_W+1)'(r_top))
            w_fin_status = ST_FULL;
    end

    assign w_out_free = !r_o_valid || !i_stall;
    assign w_finish   = r_wait && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_wait    <= 1'b0;
            r_hit     <= 1'b0;
            r_fail    <= 1'b0;
            r_ins     <= 1'b0;
            r_del     <= 1'b0;
            r_t       <= '0;
            r_count   <= '0;
            r_top     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_valid)
                r_top <= i_top_limit;
            if (w_accept) begin
                r_busy <= 1'b1;
                r_wait <= 1'b0;
                r_hit  <= 1'b0;
                r_fail <= 1'b0;
                r_ins  <= 1'b0;
                r_del  <= 1'b0;
                r_t    <= '0;
            end else if (w_scan) begin
                r_t <= r_t + 1'b1;
                if (w_last)
                    r_wait <= 1'b1;
                if (w_hit)
                    r_hit <= 1'b1;
                if (w_fail)
                    r_fail <= 1'b1;
                if (w_commit)
                    r_ins <= 1'b1;
                if (w_hit && r_act == ACT_FREE)
                    r_del <= 1'b1;
            end else if (w_finish) begin
                r_busy <= 1'b0;
                r_wait <= 1'b0;
                if (w_fin_status == ST_OK) begin
                    if (r_act == ACT_FREE)
                        r_count <= r_count - 1'b1;
                    else
                        r_count <= r_count + 1'b1;
                end
            end
            if (w_finish)
                r_o_valid <= 1'b1;
            else if (!i_stall)
                r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act        <= i_action;
            r_addr       <= i_address & ~PAGE_MASK;
            r_len        <= w_len_al;
            r_res_start  <= '0;
            r_res_status <= (i_action == ACT_FREE) ? ST_NOTFOUND : ST_NOSPACE;
        end else if (w_scan) begin
            r_prev_end <= w_cur.rng_end;
            if (r_ins || w_commit)
                r_hold <= w_cur;
            if (w_hit) begin
                if (r_act == ACT_FREE || w_commit) begin
                    r_res_start  <= w_where;
                    r_res_status <= ST_OK;
                end else begin
                    r_res_status <= ST_FULL;
                end
            end
        end
        if (w_finish) begin
            r_o_start  <= (w_fin_status == ST_OK) ? r_res_start : '0;
            r_o_status <= w_fin_status;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_start_address = r_o_start;
    assign o_status        = r_o_status;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_RANGES))
        else $error("range count above table size");
    a_wait_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wait |-> r_busy)
        else $error("wait phase outside a request");
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_busy && !r_wait && r_t == '0)
        else $error("scan did not start at entry zero");
    a_result_from_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_wait))
        else $error("result beat without a finished pass");
    a_single_edit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_ins && r_del))
        else $error("insert and delete in one pass");
`endif

endmodule

// ===== verif/tb_address_range_allocator.sv =====
`timescale 1ns / 100ps

module tb_address_range_allocator;
    import aral_pkg::*;

    localparam int HOLD_CYCLES = 700;     // long receiver hold-off
    localparam int SETTLE      = 300;     // > one full turn of the cell ring
    localparam int IDLE_LIMIT  = 5000;    // watchdog: cycles without any beat

    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]        act;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] len;
    } t_req;

    typedef struct {
        logic [ADDR_W-1:0] start_addr;
        logic [1:0]        status;
    } t_alloc_res;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [1:0]        i_action;
    logic [ADDR_W-1:0] i_address;
    logic [ADDR_W-1:0] i_length;
    logic              o_valid;
    logic              i_stall;
    logic [ADDR_W-1:0] o_start_address;
    logic [1:0]        o_status;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [ADDR_W-1:0] i_top_limit;

    address_range_allocator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_action        (i_action),
        .i_address       (i_address),
        .i_length        (i_length),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_start_address (o_start_address),
        .o_status        (o_status),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_top_limit     (i_top_limit)
    );

    // requests waiting to be driven, and results the allocator still owes
    t_req       pending_reqs[$];
    t_alloc_res owed_results[$];

    // shadow of the allocator: sorted live ranges and limit
    logic [ADDR_W-1:0] shadow_start[MAX_RANGES];
    logic [ADDR_W-1:0] shadow_end[MAX_RANGES];
    int                shadow_count;
    logic [ADDR_W-1:0] shadow_top;

    int errors;
    int tx_wait, rx_wait, rx_hold;
    bit tx_fast, rx_fast;
    int hold_req, hold_seen;
    int idle_cycles;

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // works out the result of one request and updates the shadow table
    function automatic t_alloc_res allocate_step(input t_req r);
        t_alloc_res res;
        logic [63:0] a, l, rem, where, base;
        int slot, i;
        bit ok;
        res.start_addr = '0;
        res.status     = ST_NOSPACE;
        a     = {32'd0, r.addr};
        l     = {32'd0, r.len};
        where = 0;
        slot  = 0;
        ok    = 0;
        a = a - (a % PAGE_BYTES);
        rem = l % PAGE_BYTES;
        if (rem != 0) l = l + PAGE_BYTES - rem;
        if (r.act == ACT_PLACE || r.act == ACT_FIXED) begin
            if (shadow_count == 0) begin
                ok = 1;
                where = a;
            end else if (r.act == ACT_PLACE) begin
                // first gap at or above the hint, else the tail up to the limit
                for (i = 0; i < shadow_count && !ok; i++) begin
                    base = (i == 0) ? 64'd0 : {32'd0, shadow_end[i-1]};
                    if (base >= a && {32'd0, shadow_start[i]} >= base &&
                        {32'd0, shadow_start[i]} - base >= l) begin
                        ok = 1;
                        where = base;
                        slot = i;
                    end
                end
                if (!ok) begin
                    base = {32'd0, shadow_end[shadow_count-1]};
                    if ({32'd0, shadow_top} >= base && {32'd0, shadow_top} - base >= l) begin
                        ok = 1;
                        where = base;
                        slot = shadow_count;
                    end
                end
            end else begin
                // fixed: must end before some range and start no lower than the end of the one before
                where = a;
                for (i = 0; i < shadow_count; i++) begin
                    base = (i == 0) ? 64'd0 : {32'd0, shadow_end[i-1]};
                    if (base > a) break;
                    if (a + l <= {32'd0, shadow_start[i]}) begin
                        ok = 1;
                        slot = i;
                        break;
                    end
                end
            end
            if (!ok || where + l > 64'hFFFF_FFFF) return res;
            if (shadow_count >= MAX_RANGES) begin
                res.status = ST_FULL;
                return res;
            end
            for (i = shadow_count; i > slot; i--) begin
                shadow_start[i] = shadow_start[i-1];
                shadow_end[i]   = shadow_end[i-1];
            end
            shadow_start[slot] = where[31:0];
            shadow_end[slot]   = 32'(where + l);
            shadow_count++;
            res.start_addr = where[31:0];
            res.status     = ST_OK;
        end else if (r.act == ACT_FREE) begin
            for (i = 0; i < shadow_count; i++)
                if (a >= {32'd0, shadow_start[i]} && a < {32'd0, shadow_end[i]}) break;
            if (i >= shadow_count) begin
                res.status = ST_NOTFOUND;
                return res;
            end
            res.start_addr = shadow_start[i];
            res.status     = ST_OK;
            for (; i + 1 < shadow_count; i++) begin
                shadow_start[i] = shadow_start[i+1];
                shadow_end[i]   = shadow_end[i+1];
            end
            shadow_count--;
        end
        return res;
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // driver: offers one request at a time, random gap before each
    always @(posedge i_clk) begin
        bit sent;
        t_req r;
        if (!i_rst_n) begin
            i_valid   <= 0;
            i_action  <= ACT_PLACE;
            i_address <= '0;
            i_length  <= '0;
            tx_wait   = 0;
        end else begin
            sent = i_valid && !o_stall;
            if (sent) begin
                owed_results.push_back(allocate_step('{i_action, i_address, i_length}));
                tx_wait = tx_fast ? 0 : $urandom_range(0, 15);
            end
            if (sent || !i_valid) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    i_valid <= 0;
                end else if (pending_reqs.size() > 0) begin
                    r = pending_reqs.pop_front();
                    i_action  <= r.act;
                    i_address <= r.addr;
                    i_length  <= r.len;
                    i_valid   <= 1;
                end else begin
                    i_valid <= 0;
                end
            end
        end
    end

    // monitor: random stall per result beat, plus the occasional long hold-off
    always @(posedge i_clk) begin
        t_alloc_res exp_res;
        if (!i_rst_n) begin
            i_stall   <= 0;
            rx_wait   = 0;
            rx_hold   = 0;
            hold_seen = 0;
        end else begin
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                rx_hold   = HOLD_CYCLES;
            end
            if (o_valid && !i_stall) begin
                if (owed_results.size() == 0) begin
                    report($sformatf("unexpected result beat start=%h status=%0d",
                                     o_start_address, o_status));
                end else begin
                    exp_res = owed_results.pop_front();
                    if (o_start_address !== exp_res.start_addr)
                        report($sformatf("start_address %h, expected %h",
                                         o_start_address, exp_res.start_addr));
                    if (o_status !== exp_res.status)
                        report($sformatf("status %0d, expected %0d",
                                         o_status, exp_res.status));
                end
                rx_wait = rx_fast ? 0 : $urandom_range(0, 15);
            end else if (rx_hold > 0) begin
                rx_hold--;
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            i_stall <= (rx_hold > 0 || rx_wait > 0);
        end
    end

    // watchdog: cycles with no beat on any channel
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic queue_req(input logic [1:0] act, input logic [31:0] addr,
                             input logic [31:0] len);
        pending_reqs.push_back('{act, addr, len});
    endtask

    task automatic write_top_limit(input logic [31:0] value);
        i_cfg_valid <= 1;
        i_top_limit <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        shadow_top = value;
    endtask

    // wait until everything issued has come back and the ring has settled
    task automatic drain;
        wait (pending_reqs.size() == 0 && owed_results.size() == 0 && !i_valid);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // mostly a small window of pages so that ranges collide and frees hit
    function automatic logic [31:0] rand_addr();
        if ($urandom_range(0, 9) == 0) return $urandom;
        return ($urandom_range(0, 511) << 12) | $urandom_range(0, 4095);
    endfunction

    function automatic logic [31:0] rand_len();
        int k;
        k = $urandom_range(0, 19);
        if (k < 3) return $urandom;
        if (k < 5) return $urandom_range(0, 4095);
        return ($urandom_range(0, 4) << 12) - $urandom_range(0, 1);
    endfunction

    initial begin
        logic [1:0] act;
        int k, ph;
        logic [31:0] limits[4];
        errors       = 0;
        shadow_count = 0;
        shadow_top   = '0;
        hold_req     = 0;
        tx_fast      = 0;
        rx_fast      = 0;
        idle_cycles  = 0;
        i_rst_n      = 0;
        i_cfg_valid  = 0;
        i_top_limit  = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: empty table, gaps, tail limit, overflow, zero length, unused code
        write_top_limit(32'h0);
        queue_req(ACT_FREE,   32'h0000_5000, 32'h0);          // free on empty table
        queue_req(ACT_PLACE,  32'h1234_5FFF, 32'h1);          // empty table, no limit check
        queue_req(ACT_PLACE,  32'h0,         32'h1000);       // gap below first range
        queue_req(ACT_PLACE,  32'h0,         32'h1000);       // gap after the first range
        queue_req(ACT_FIXED,  32'h0000_5123, 32'h1FFF);       // fixed before a range
        queue_req(ACT_FIXED,  32'h0000_5000, 32'h1000);       // overlaps
        queue_req(ACT_FIXED,  32'hFFFF_F000, 32'h1000);       // after the last range
        queue_req(ACT_PLACE,  32'h0,         32'hFFFF_FFFF);  // end beyond 32 bits
        queue_req(ACT_FIXED,  32'h0000_2000, 32'h0);          // zero length
        queue_req(ACT_FREE,   32'h0000_2000, 32'h0);          // zero length never freed
        queue_req(ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // unused code
        queue_req(ACT_FREE,   32'h1234_5ABC, 32'hFFFF_FFFF);
        queue_req(ACT_FREE,   32'h0000_0FFF, 32'h0);
        drain();
        write_top_limit(32'hFFFF_FFFF);
        queue_req(ACT_PLACE, 32'hFFFF_E000, 32'h1000);
        queue_req(ACT_PLACE, 32'h8000_0000, 32'h7FFF_F001);
        queue_req(ACT_PLACE, 32'h0,         32'hFFFF_FFFF);
        queue_req(ACT_FIXED, 32'h0,         32'h0);
        queue_req(ACT_FREE,  32'hFFFF_EFFF, 32'h0);
        queue_req(ACT_FREE,  32'h5000_0000, 32'h0);
        drain();

        // fill the table past full behind a long receiver hold-off, then free at random addresses
        tx_fast = 1;
        hold_req++;
        for (k = 0; k < 270; k++)
            queue_req(ACT_PLACE, 32'h0, $urandom_range(1, 4096));
        wait (pending_reqs.size() == 200);
        tx_fast = 0;
        for (k = 0; k < 260; k++)
            queue_req(ACT_FREE, $urandom_range(0, 300) << 12 | $urandom_range(0, 4095),
                      $urandom);
        drain();

        limits[0] = 32'h0008_0000;
        limits[1] = 32'h0020_0000;
        limits[2] = $urandom;
        limits[3] = 32'h0;
        for (ph = 0; ph < 4; ph++) begin
            write_top_limit(limits[ph]);
            tx_fast = (ph == 1);
            rx_fast = (ph == 2);
            for (k = 0; k < 270; k++) begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7: act = ACT_PLACE;
                    8, 9, 10, 11:           act = ACT_FIXED;
                    18:                     act = ACT_UNUSED;
                    default:                act = ACT_FREE;
                endcase
                queue_req(act, rand_addr(), rand_len());
            end
            drain();
        end

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
